[sv/md64_pkg.sv]
// Package with the word types and constants of the multiply-divide unit.
`timescale 1ns / 1ps
package md64_pkg;
	localparam int unsigned DivSteps = 64;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [63:0] operand_a;
		logic [63:0] operand_b;
		logic [63:0] divisor;
	} md_in_t;

	typedef struct packed {
		logic [63:0] quotient;
		logic        overflow;
		logic        divide_by_zero;
	} md_out_t;

	// Divider pipeline word: partial remainder, dividend bits still to shift
	// in, quotient so far, divisor and the early-out flags.
	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] lo;
		logic [63:0] q;
		logic [63:0] d;
		logic        ovf;
		logic        dbz;
	} md_div_t;

	function automatic md_div_t div_step(input md_div_t x);
		md_div_t y;
		logic    top;
		logic [64:0] diff;
		logic [63:0] sh;
		y    = x;
		top  = x.rem[63];
		sh   = {x.rem[62:0], x.lo[63]};
		diff = {top, sh} - {1'b0, x.d};
		y.lo = {x.lo[62:0], 1'b0};
		if (top || !diff[64]) begin
			y.rem = diff[63:0];
			y.q   = {x.q[62:0], 1'b1};
		end else begin
			y.rem = sh;
			y.q   = {x.q[62:0], 1'b0};
		end
		return y;
	endfunction
endpackage

[sv/mul_div_64.sv]
// Pipelined saturating unsigned 64x64/64 multiply-divide.
// Throughput: one word per cycle when not stalled; one multiply stage, two add stages,
// 64 divide stages of one restoring step each, and an output register.
// A stall holds every stage; reset clears all valid bits asynchronously.
`timescale 1ns / 1ps
module mul_div_64 (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  md64_pkg::md_in_t    in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output md64_pkg::md_out_t   out_data
);
	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// Stage 1: four 32x32 partial products.
	logic        v_s1;
	logic [63:0] p00_s1, p01_s1, p10_s1, p11_s1, d_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			p00_s1 <= 64'(in_data.operand_a[31:0]) * 64'(in_data.operand_b[31:0]);
			p01_s1 <= 64'(in_data.operand_a[31:0]) * 64'(in_data.operand_b[63:32]);
			p10_s1 <= 64'(in_data.operand_a[63:32]) * 64'(in_data.operand_b[31:0]);
			p11_s1 <= 64'(in_data.operand_a[63:32]) * 64'(in_data.operand_b[63:32]);
			d_s1   <= in_data.divisor;
		end
	end

	// Stage 2: middle column sum.
	logic        v_s2;
	logic [33:0] mid_s2;
	logic [63:0] p00_s2, p01_s2, p10_s2, p11_s2, d_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			mid_s2 <= 34'(p00_s1[63:32]) + 34'(p01_s1[31:0]) + 34'(p10_s1[31:0]);
			p00_s2 <= p00_s1;
			p01_s2 <= p01_s1;
			p10_s2 <= p10_s1;
			p11_s2 <= p11_s1;
			d_s2   <= d_s1;
		end
	end

	// Stage 3: high word, flags and divider seed.
	logic        v_s3;
	md64_pkg::md_div_t x_s3;
	logic [63:0] hi2;
	assign hi2 = p11_s2 + 64'(p01_s2[63:32]) + 64'(p10_s2[63:32]) + 64'(mid_s2[33:32]);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s3.rem <= hi2;
			x_s3.lo  <= {mid_s2[31:0], p00_s2[31:0]};
			x_s3.q   <= '0;
			x_s3.d   <= d_s2;
			x_s3.dbz <= (d_s2 == '0);
			x_s3.ovf <= (d_s2 != '0) && (hi2 >= d_s2);
		end
	end

	// Divide stages: one restoring step per register.
	logic              dv_s4 [md64_pkg::DivSteps];
	md64_pkg::md_div_t dx_s4 [md64_pkg::DivSteps];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < md64_pkg::DivSteps; i++) dv_s4[i] <= 1'b0;
		end else if (adv) begin
			dv_s4[0] <= v_s3;
			for (int i = 1; i < md64_pkg::DivSteps; i++) dv_s4[i] <= dv_s4[i-1];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s4[0] <= md64_pkg::div_step(x_s3);
			for (int i = 1; i < md64_pkg::DivSteps; i++)
				dx_s4[i] <= md64_pkg::div_step(dx_s4[i-1]);
		end
	end

	// Output register.
	md64_pkg::md_div_t fin;
	assign fin = dx_s4[md64_pkg::DivSteps-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= dv_s4[md64_pkg::DivSteps-1];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.quotient       <= (fin.ovf || fin.dbz) ? md64_pkg::ALL_ONES : fin.q;
			out_data.overflow       <= fin.ovf;
			out_data.divide_by_zero <= fin.dbz;
		end
	end

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.overflow && out_data.divide_by_zero))
		else $error("overflow and divide_by_zero both set");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.overflow || out_data.divide_by_zero))
		|-> out_data.quotient == md64_pkg::ALL_ONES)
		else $error("flagged word not saturated");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pipeline stalled with empty output");
endmodule
